// File: rtl/core/bmp_pkg.sv
package bmp_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIMENSION_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // Header bytes of interest
    localparam logic [7:0]  ASCII_B      = 8'h42;
    localparam logic [7:0]  ASCII_M      = 8'h4D;
    localparam logic [31:0] OS2_HDR_SIZE = 32'd12;
    localparam logic [15:0] BPP_24       = 16'd24;
    localparam logic [15:0] BPP_32       = 16'd32;

    // Byte offsets (last byte of each little-endian field)
    localparam logic [5:0] HDR_SIG0       = 6'd0;
    localparam logic [5:0] HDR_SIG1       = 6'd1;
    localparam logic [5:0] HDR_SIZE_END   = 6'd17;
    localparam logic [5:0] OS2_WIDTH_END  = 6'd19;
    localparam logic [5:0] OS2_HEIGHT_END = 6'd21;
    localparam logic [5:0] OS2_BPP_END    = 6'd25;
    localparam logic [5:0] WIN_WIDTH_END  = 6'd21;
    localparam logic [5:0] WIN_HEIGHT_END = 6'd25;
    localparam logic [5:0] WIN_BPP_END    = 6'd29;
    localparam logic [5:0] WIN_COMP_END   = 6'd33;
    localparam logic [5:0] WIN_HDR_END    = 6'd53;

    // Result status codes
    localparam logic [1:0] ST_PIXEL   = 2'd0;
    localparam logic [1:0] ST_BAD_SIG = 2'd1;
    localparam logic [1:0] ST_BAD_FMT = 2'd2;
    localparam logic [1:0] ST_BAD_DIM = 2'd3;

    // Byte slots within a pixel
    localparam logic [1:0] SLOT_BLUE  = 2'd0;
    localparam logic [1:0] SLOT_GREEN = 2'd1;
    localparam logic [1:0] SLOT_RED   = 2'd2;
    localparam logic [1:0] SLOT_LAST24 = 2'd2;
    localparam logic [1:0] SLOT_LAST32 = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PIXELS,
        PH_PAD
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_bmp_in;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] line;
        logic        last_pixel;
        logic [1:0]  status;
    } t_bmp_out;

    // Classified byte handed from the parser to the pixel builder
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [1:0]  slot;
        logic        end_of_pixel;
        logic        four_byte;
        logic [11:0] column;
        logic [11:0] line;
        logic        last_pixel;
        logic [1:0]  status;
    } t_bmp_cmd;

endpackage

// File: rtl/core/bmp_fifo.sv
module bmp_fifo
    import bmp_pkg::*;
#(
    parameter type t_item = t_bmp_cmd,
    parameter int  DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_data,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/bmp_front.sv
module bmp_front
    import bmp_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_bmp_in  i_in,
    output logic     o_cmd_push,
    output t_bmp_cmd o_cmd
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

    t_phase             r_phase, n_phase;
    logic [5:0]         r_hdr_cnt, n_hdr_cnt;
    logic [31:0]        r_field, n_field;
    logic               r_short, n_short;
    logic               r_fmt_bad, n_fmt_bad;
    logic               r_four, n_four;
    logic [DIM_W-1:0]   r_w, n_w;
    logic [DIM_W-1:0]   r_h, n_h;
    logic               r_w_ok, n_w_ok;
    logic               r_h_ok, n_h_ok;
    logic [1:0]         r_bip, n_bip;
    logic [DIM_W-1:0]   r_col, n_col;
    logic [DIM_W-1:0]   r_row, n_row;
    logic [1:0]         r_pad, n_pad;

    logic               start;
    t_phase             cur_phase;
    logic [5:0]         hdr_n;
    logic [31:0]        field_new;
    logic [15:0]        half;
    logic               short_now;
    logic               sig_bad;
    logic               fmt_bad_base;
    logic               fmt_bad_now;
    logic               hdr_done;
    logic               size_ok;
    logic [31:0]        cap_val;
    logic               cap_ok;
    logic               cap_w;
    logic               cap_h;
    logic               mid_pixel;
    logic [DIM_W-1:0]   col_inc;
    logic [DIM_W-1:0]   row_inc;
    logic               is_last;
    logic               row_end;
    logic               pad_need;

    // A start byte always restarts at header byte 0
    assign start     = i_in.start_of_file;
    assign cur_phase = start ? PH_HEADER : r_phase;
    assign hdr_n     = start ? '0 : r_hdr_cnt;
    assign field_new = {i_in.data_byte, (start ? 24'd0 : r_field[31:8])};
    assign half      = field_new[31:16];

    // Header decode
    assign short_now = (hdr_n == HDR_SIZE_END) ? (field_new == OS2_HDR_SIZE)
                                               : (!start && r_short);
    assign sig_bad   = ((hdr_n == HDR_SIG0) && (i_in.data_byte != ASCII_B)) ||
                       ((hdr_n == HDR_SIG1) && (i_in.data_byte != ASCII_M));
    assign fmt_bad_base = !start && r_fmt_bad;

    always_comb begin
        fmt_bad_now = fmt_bad_base;
        if (short_now) begin
            if (hdr_n == OS2_BPP_END) begin
                fmt_bad_now = (half != BPP_24);
            end
        end else begin
            if (hdr_n == WIN_BPP_END) begin
                fmt_bad_now = !((half == BPP_24) || (half == BPP_32));
            end else if (hdr_n == WIN_COMP_END) begin
                fmt_bad_now = fmt_bad_base || (field_new != '0);
            end
        end
    end

    assign hdr_done = short_now ? (hdr_n == OS2_BPP_END) : (hdr_n == WIN_HDR_END);
    assign size_ok  = r_w_ok && r_h_ok;

    // Dimension capture; a negative Windows value reads as too large
    assign cap_val = short_now ? {16'd0, half} : field_new;
    assign cap_ok  = (cap_val != '0) && (cap_val <= 32'(MAX_DIMENSION));
    assign cap_w   = short_now ? (hdr_n == OS2_WIDTH_END)  : (hdr_n == WIN_WIDTH_END);
    assign cap_h   = short_now ? (hdr_n == OS2_HEIGHT_END) : (hdr_n == WIN_HEIGHT_END);

    // Pixel walk
    assign mid_pixel = r_bip < (r_four ? SLOT_LAST32 : SLOT_LAST24);
    assign col_inc   = r_col + 1'b1;
    assign row_inc   = r_row + 1'b1;
    assign is_last   = (col_inc == r_w) && (row_inc == r_h);
    assign row_end   = (col_inc >= r_w);
    // 24-bit rows pad to four bytes: pad count equals width mod 4
    assign pad_need  = !r_four && (2'(r_w) != 2'd0);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            unique case (cur_phase)
                PH_HEADER: begin
                    if (sig_bad) begin
                        n_phase = PH_IDLE;
                    end else if (hdr_done) begin
                        n_phase = (fmt_bad_now || !size_ok) ? PH_IDLE : PH_PIXELS;
                    end else begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_PIXELS: begin
                    if (!mid_pixel) begin
                        if (is_last) begin
                            n_phase = PH_IDLE;
                        end else if (row_end && pad_need) begin
                            n_phase = PH_PAD;
                        end
                    end
                end
                PH_PAD: begin
                    if (r_pad == 2'd1) begin
                        n_phase = PH_PIXELS;
                    end
                end
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Beats for the pixel builder: pixel bytes and errors
    always_comb begin
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        if (i_accept) begin
            unique case (cur_phase)
                PH_HEADER: begin
                    o_cmd.end_of_pixel = 1'b1;
                    if (sig_bad) begin
                        o_cmd_push   = 1'b1;
                        o_cmd.status = ST_BAD_SIG;
                    end else if (hdr_done && fmt_bad_now) begin
                        o_cmd_push   = 1'b1;
                        o_cmd.status = ST_BAD_FMT;
                    end else if (hdr_done && !size_ok) begin
                        o_cmd_push   = 1'b1;
                        o_cmd.status = ST_BAD_DIM;
                    end
                end
                PH_PIXELS: begin
                    o_cmd_push         = 1'b1;
                    o_cmd.data_byte    = i_in.data_byte;
                    o_cmd.slot         = r_bip;
                    o_cmd.end_of_pixel = !mid_pixel;
                    o_cmd.four_byte    = r_four;
                    o_cmd.column       = 12'(r_col);
                    o_cmd.line         = 12'(r_row);
                    o_cmd.last_pixel   = is_last;
                    o_cmd.status       = ST_PIXEL;
                end
                PH_PAD, PH_IDLE: begin
                    o_cmd_push = 1'b0;
                end
                default: begin
                    o_cmd_push = 1'b0;
                end
            endcase
        end
    end

    // Header fields and counters
    always_comb begin
        n_hdr_cnt = r_hdr_cnt;
        n_field   = r_field;
        n_short   = r_short;
        n_fmt_bad = r_fmt_bad;
        n_four    = r_four;
        n_w       = r_w;
        n_h       = r_h;
        n_w_ok    = r_w_ok;
        n_h_ok    = r_h_ok;
        n_bip     = r_bip;
        n_col     = r_col;
        n_row     = r_row;
        n_pad     = r_pad;
        if (i_accept) begin
            if (start) begin
                n_four = 1'b0;
                n_w_ok = 1'b0;
                n_h_ok = 1'b0;
            end
            case (cur_phase)
                PH_HEADER: begin
                    n_hdr_cnt = hdr_n + 1'b1;
                    n_field   = field_new;
                    n_short   = short_now;
                    n_fmt_bad = fmt_bad_now;
                    if (cap_w) begin
                        n_w    = DIM_W'(cap_val);
                        n_w_ok = cap_ok;
                    end
                    if (cap_h) begin
                        n_h    = DIM_W'(cap_val);
                        n_h_ok = cap_ok;
                    end
                    if (short_now && (hdr_n == OS2_BPP_END)) begin
                        n_four = 1'b0;
                    end else if (!short_now && (hdr_n == WIN_BPP_END)) begin
                        n_four = (half == BPP_32);
                    end
                    if (hdr_done) begin
                        n_bip = '0;
                        n_col = '0;
                        n_row = '0;
                        n_pad = '0;
                    end
                end
                PH_PIXELS: begin
                    if (mid_pixel) begin
                        n_bip = r_bip + 1'b1;
                    end else begin
                        n_bip = '0;
                        if (!is_last && row_end) begin
                            n_col = '0;
                            n_row = row_inc;
                            if (pad_need) begin
                                n_pad = 2'(r_w);
                            end
                        end else begin
                            n_col = col_inc;
                        end
                    end
                end
                PH_PAD: begin
                    n_pad = r_pad - 1'b1;
                end
                default: begin
                    n_pad = r_pad;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_hdr_cnt <= '0;
            r_short   <= 1'b0;
            r_fmt_bad <= 1'b0;
            r_four    <= 1'b0;
            r_w_ok    <= 1'b0;
            r_h_ok    <= 1'b0;
            r_bip     <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_pad     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_short   <= n_short;
            r_fmt_bad <= n_fmt_bad;
            r_four    <= n_four;
            r_w_ok    <= n_w_ok;
            r_h_ok    <= n_h_ok;
            r_bip     <= n_bip;
            r_col     <= n_col;
            r_row     <= n_row;
            r_pad     <= n_pad;
        end
    end

    // Header payload
    always_ff @(posedge i_clk) begin
        r_field <= n_field;
        r_w     <= n_w;
        r_h     <= n_h;
    end

endmodule

// File: rtl/core/bmp_back.sv
module bmp_back
    import bmp_pkg::*;
(
    input  logic     i_clk,
    input  t_bmp_cmd i_cmd,
    input  logic     i_cmd_empty,
    output logic     o_cmd_pop,
    input  logic     i_res_full,
    output logic     o_res_push,
    output t_bmp_out o_res
);

    logic [23:0] r_held;
    logic        cmd_valid;
    logic [7:0]  colour_or;

    assign cmd_valid  = !i_cmd_empty;
    // A colour byte never waits; a closing byte waits for result room
    assign o_cmd_pop  = cmd_valid && (!i_cmd.end_of_pixel || !i_res_full);
    assign o_res_push = cmd_valid && i_cmd.end_of_pixel && !i_res_full;

    // Hold B, G (and R for 32-bit) until the closing byte
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && !i_cmd.end_of_pixel) begin
            case (i_cmd.slot)
                SLOT_BLUE:  r_held[7:0]   <= i_cmd.data_byte;
                SLOT_GREEN: r_held[15:8]  <= i_cmd.data_byte;
                SLOT_RED:   r_held[23:16] <= i_cmd.data_byte;
                default:    r_held        <= r_held;
            endcase
        end
    end

    assign colour_or = i_cmd.data_byte | r_held[15:8] | r_held[7:0];

    // Build the RGBA result, or a blank one carrying an error status
    always_comb begin
        o_res        = '0;
        o_res.status = i_cmd.status;
        if (i_cmd.status == ST_PIXEL) begin
            o_res.blue       = r_held[7:0];
            o_res.green      = r_held[15:8];
            o_res.column     = i_cmd.column;
            o_res.line       = i_cmd.line;
            o_res.last_pixel = i_cmd.last_pixel;
            if (i_cmd.four_byte) begin
                o_res.red   = r_held[23:16];
                o_res.alpha = i_cmd.data_byte;
            end else begin
                o_res.red   = i_cmd.data_byte;
                o_res.alpha = (colour_or == 8'd0) ? 8'd0 : 8'hFF;
            end
        end
    end

endmodule

// File: rtl/core/bmp_stream_to_rgba_decoder_top.sv
// Bitmap stream decoder: takes one file byte per beat (start_of_file marks byte 0
// and restarts parsing) and returns one RGBA result per image pixel, rows in file
// order, for uncompressed 24-bit files in the OS/2 header layout and 24-bit or
// 32-bit ones in the Windows layout. Bytes are accepted at one per cycle while
// full is low; full rises only when the two-entry queue between the header parser
// and the pixel builder fills, which happens when results are not popped. A pixel
// is built once its closing byte leaves that queue and the result queue has room.
// Header bytes (26 for OS/2, 54 for Windows) and row padding produce nothing; a
// bad signature, an unsupported format or an out-of-range size gives a single
// result with a non-zero status and halts decoding until the next start byte.
module bmp_stream_to_rgba_decoder_top
    import bmp_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  t_bmp_in  i_byte_in,
    output logic     full,
    output logic     empty,
    input  logic     pop,
    output t_bmp_out o_pixel
);

    logic     accept;
    logic     cmd_push;
    t_bmp_cmd cmd_in;
    t_bmp_cmd cmd_head;
    logic     cmd_full;
    logic     cmd_empty;
    logic     cmd_pop;
    logic     res_push;
    t_bmp_out res_in;
    logic     res_full;

    assign accept = push && !cmd_full;
    assign full   = cmd_full;

    // Header parser and byte classifier
    bmp_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in       (i_byte_in),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    // Queue of classified beats
    bmp_fifo #(
        .t_item (t_bmp_cmd),
        .DEPTH  (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    // Pixel builder
    bmp_back u_back (
        .i_clk       (i_clk),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Result queue
    bmp_fifo #(
        .t_item (t_bmp_out),
        .DEPTH  (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_pixel),
        .o_empty (empty)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import bmp_pkg::*;
();

    localparam int          DIM_LIMIT    = MAX_DIMENSION_DEF;
    localparam logic [31:0] WIN_HDR_LEN  = 32'd40;
    localparam logic [31:0] V4_HDR_LEN   = 32'd108;
    localparam int          RANDOM_BYTES = 200;
    localparam int          MAX_REPORTS  = 10;

    // Colour content of generated pixel data
    localparam int FILL_MIXED = 0;
    localparam int FILL_BLACK = 1;
    localparam int FILL_WHITE = 2;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push    = 1'b0;
    t_bmp_in  i_byte_in = '0;
    logic     full;
    logic     empty;
    logic     pop     = 1'b0;
    t_bmp_out o_pixel;

    // Stimulus and expectations
    t_bmp_in  byte_queue[$];
    t_bmp_out pixel_due[$];
    int       queued_bytes = 0;
    int       bad_count    = 0;
    int       burst_left   = 0;
    int       gap_left     = 0;
    int       rx_cycle     = 0;
    int       hold_left    = 0;
    bit       hold_req     = 1'b0;
    bit       hold_taken   = 1'b0;

    // Decoder state mirrored in the testbench
    t_phase      dec_phase;
    logic [5:0]  hdr_idx;
    logic [31:0] hdr_shift;
    logic [31:0] img_w;
    logic [31:0] img_h;
    logic        px32;
    logic [1:0]  px_slot;
    logic [31:0] col_idx;
    logic [31:0] row_idx;
    logic [1:0]  pad_left;
    logic [23:0] colour_acc;
    logic        os2_hdr;
    logic        fmt_err;

    bmp_stream_to_rgba_decoder_top #(
        .MAX_DIMENSION(DIM_LIMIT)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_byte_in(i_byte_in),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_pixel  (o_pixel)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void clear_decoder();
        dec_phase  = PH_IDLE;
        hdr_idx    = '0;
        hdr_shift  = '0;
        img_w      = '0;
        img_h      = '0;
        px32       = 1'b0;
        px_slot    = '0;
        col_idx    = '0;
        row_idx    = '0;
        pad_left   = '0;
        colour_acc = '0;
        os2_hdr    = 1'b0;
        fmt_err    = 1'b0;
    endfunction

    function automatic string pix_text(input t_bmp_out p);
        return $sformatf("r%02h g%02h b%02h a%02h col %0d line %0d last %0b st %0d",
                         p.red, p.green, p.blue, p.alpha, p.column, p.line,
                         p.last_pixel, p.status);
    endfunction

    // Advance the mirrored decoder by one byte; returns 1 when a result is due
    function automatic bit decode_byte(input t_bmp_in beat, output t_bmp_out pix);
        logic [7:0]  b;
        logic [5:0]  n;
        logic [15:0] half;
        logic [1:0]  last_slot;
        logic [1:0]  pad_fill;
        bit          hdr_done;
        bit          fire;
        b        = beat.data_byte;
        pix      = '0;
        fire     = 1'b0;
        hdr_done = 1'b0;
        if (beat.start_of_file) begin
            clear_decoder();
            dec_phase = PH_HEADER;
        end
        case (dec_phase)
            PH_HEADER: begin
                n         = hdr_idx;
                hdr_shift = {b, hdr_shift[31:8]};
                half      = hdr_shift[31:16];
                hdr_idx   = n + 6'd1;
                if ((n == HDR_SIG0 && b != ASCII_B) || (n == HDR_SIG1 && b != ASCII_M)) begin
                    fire       = 1'b1;
                    pix.status = ST_BAD_SIG;
                    dec_phase  = PH_IDLE;
                end else begin
                    if (n == HDR_SIZE_END)
                        os2_hdr = (hdr_shift == OS2_HDR_SIZE);
                    if (os2_hdr) begin
                        if (n == OS2_WIDTH_END)  img_w = {16'h0, half};
                        if (n == OS2_HEIGHT_END) img_h = {16'h0, half};
                        if (n == OS2_BPP_END) begin
                            fmt_err  = (half != BPP_24);
                            px32     = 1'b0;
                            hdr_done = 1'b1;
                        end
                    end else begin
                        if (n == WIN_WIDTH_END)  img_w = hdr_shift;
                        if (n == WIN_HEIGHT_END) img_h = hdr_shift;
                        if (n == WIN_BPP_END) begin
                            fmt_err = !(half == BPP_24 || half == BPP_32);
                            px32    = (half == BPP_32);
                        end
                        if (n == WIN_COMP_END && hdr_shift != 0)
                            fmt_err = 1'b1;
                        if (n == WIN_HDR_END)
                            hdr_done = 1'b1;
                    end
                    if (hdr_done) begin
                        // format errors win over size errors
                        if (fmt_err) begin
                            fire       = 1'b1;
                            pix.status = ST_BAD_FMT;
                            dec_phase  = PH_IDLE;
                        end else if (img_w == 0 || img_w > DIM_LIMIT ||
                                     img_h == 0 || img_h > DIM_LIMIT) begin
                            fire       = 1'b1;
                            pix.status = ST_BAD_DIM;
                            dec_phase  = PH_IDLE;
                        end else begin
                            dec_phase  = PH_PIXELS;
                            px_slot    = '0;
                            col_idx    = '0;
                            row_idx    = '0;
                            pad_left   = '0;
                            colour_acc = '0;
                        end
                    end
                end
            end
            PH_PIXELS: begin
                last_slot = px32 ? SLOT_LAST32 : SLOT_LAST24;
                if (px_slot < last_slot) begin
                    colour_acc[int'(px_slot) * 8 +: 8] = b;
                    px_slot = px_slot + 2'd1;
                end else begin
                    pix.blue  = colour_acc[7:0];
                    pix.green = colour_acc[15:8];
                    if (px32) begin
                        pix.red   = colour_acc[23:16];
                        pix.alpha = b;
                    end else begin
                        pix.red   = b;
                        pix.alpha = ((b | colour_acc[15:8] | colour_acc[7:0]) == 0) ?
                                    8'h00 : 8'hFF;
                    end
                    pix.column     = col_idx[11:0];
                    pix.line       = row_idx[11:0];
                    pix.last_pixel = (col_idx + 1 == img_w) && (row_idx + 1 == img_h);
                    pix.status     = ST_PIXEL;
                    fire           = 1'b1;
                    px_slot        = '0;
                    colour_acc     = '0;
                    col_idx        = col_idx + 1;
                    if (pix.last_pixel) begin
                        dec_phase = PH_IDLE;
                    end else if (col_idx >= img_w) begin
                        col_idx = '0;
                        row_idx = row_idx + 1;
                        // 24-bit rows are padded to four bytes
                        pad_fill = 2'(32'd0 - img_w * 3);
                        if (!px32 && pad_fill != 0) begin
                            pad_left  = pad_fill;
                            dec_phase = PH_PAD;
                        end
                    end
                end
            end
            PH_PAD: begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 0)
                    dec_phase = PH_PIXELS;
            end
            default: ;
        endcase
        return fire;
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic sof);
        t_bmp_in beat;
        beat.data_byte     = b;
        beat.start_of_file = sof;
        byte_queue.push_back(beat);
        queued_bytes++;
    endtask

    // Build a bitmap file; cut < 0 sends it whole, else only its first cut bytes
    task automatic queue_bitmap(input logic [31:0] hdr_len, input logic [31:0] w,
                                input logic [31:0] h, input logic [15:0] bpp,
                                input logic [31:0] comp, input bit with_pixels,
                                input int cut, input int fill);
        logic [7:0]  file_bytes[$];
        logic [15:0] planes;
        logic [7:0]  px;
        int          px_len;
        int          kind;
        int          total;
        planes = 16'($urandom);
        file_bytes.push_back(ASCII_B);
        file_bytes.push_back(ASCII_M);
        repeat (12) file_bytes.push_back(8'($urandom));
        for (int i = 0; i < 4; i++) file_bytes.push_back(hdr_len[8 * i +: 8]);
        if (hdr_len == OS2_HDR_SIZE) begin
            for (int i = 0; i < 2; i++) file_bytes.push_back(w[8 * i +: 8]);
            for (int i = 0; i < 2; i++) file_bytes.push_back(h[8 * i +: 8]);
            for (int i = 0; i < 2; i++) file_bytes.push_back(planes[8 * i +: 8]);
            for (int i = 0; i < 2; i++) file_bytes.push_back(bpp[8 * i +: 8]);
        end else begin
            for (int i = 0; i < 4; i++) file_bytes.push_back(w[8 * i +: 8]);
            for (int i = 0; i < 4; i++) file_bytes.push_back(h[8 * i +: 8]);
            for (int i = 0; i < 2; i++) file_bytes.push_back(planes[8 * i +: 8]);
            for (int i = 0; i < 2; i++) file_bytes.push_back(bpp[8 * i +: 8]);
            for (int i = 0; i < 4; i++) file_bytes.push_back(comp[8 * i +: 8]);
            repeat (20) file_bytes.push_back(8'($urandom));
        end
        if (with_pixels) begin
            px_len = (bpp == BPP_32) ? 4 : 3;
            for (int r = 0; r < int'(h); r++) begin
                for (int c = 0; c < int'(w); c++) begin
                    kind = (fill == FILL_MIXED) ? $urandom_range(0, 5) : fill;
                    for (int k = 0; k < px_len; k++) begin
                        if (kind == FILL_BLACK)
                            px = 8'h00;
                        else if (kind == FILL_WHITE)
                            px = 8'hFF;
                        else
                            px = 8'($urandom);
                        file_bytes.push_back(px);
                    end
                end
                if (px_len == 3)
                    repeat ((4 - (3 * int'(w)) % 4) % 4) file_bytes.push_back(8'($urandom));
            end
        end
        total = (cut >= 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
        for (int i = 0; i < total; i++)
            queue_byte(file_bytes[i], i == 0);
    endtask

    function automatic logic [31:0] odd_dimension();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return DIM_LIMIT;
            2:       return DIM_LIMIT + 1;
            3:       return $urandom;
            4:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    // Sender pause: wait until every queued beat has gone and every result is back
    task automatic settle_all();
        while (byte_queue.size() != 0 || push || pixel_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Driver: bursts of beats with random gaps, holding a beat while full
    always @(posedge i_clk) begin
        t_bmp_out due;
        if (!i_rst_n) begin
            push      <= 1'b0;
            i_byte_in <= '0;
            clear_decoder();
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (push && !full) begin
                if (decode_byte(i_byte_in, due))
                    pixel_due.push_back(due);
            end
            if (push && full) begin
                // beat held until accepted
            end else if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (byte_queue.size() > 0) begin
                push      <= 1'b1;
                i_byte_in <= byte_queue.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: checks each popped beat and stalls on its own pattern
    always @(posedge i_clk) begin
        t_bmp_out due;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pixel_due.size() == 0) begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                        $display("unexpected result: %s", pix_text(o_pixel));
                end else begin
                    due = pixel_due.pop_front();
                    if (o_pixel.red !== due.red || o_pixel.green !== due.green ||
                        o_pixel.blue !== due.blue || o_pixel.alpha !== due.alpha ||
                        o_pixel.column !== due.column || o_pixel.line !== due.line ||
                        o_pixel.last_pixel !== due.last_pixel ||
                        o_pixel.status !== due.status) begin
                        bad_count++;
                        if (bad_count <= MAX_REPORTS) begin
                            $display("mismatch exp: %s", pix_text(due));
                            $display("         got: %s", pix_text(o_pixel));
                        end
                    end
                end
            end
            rx_cycle++;
            if (hold_req && !hold_taken) begin
                hold_left  = 400;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (rx_cycle[8:6])
                    3'd0, 3'd1: pop <= 1'b1;
                    3'd6:       pop <= rx_cycle[1];
                    3'd7:       pop <= 1'($urandom_range(0, 1));
                    default:    pop <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Stimulus
    initial begin
        int          mark;
        int          pick;
        bit          mid_pause;
        bit          os2;
        logic [15:0] bpp;
        logic [31:0] comp;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the receiver holds off for a long stretch while the first files go in
        hold_req = 1'b1;

        // stray bytes before any start are ignored
        queue_byte(ASCII_B, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        // signature errors on the first and the second byte
        queue_byte(8'h00, 1'b1);
        queue_byte(ASCII_B, 1'b1);
        queue_byte(8'hFF, 1'b0);
        // good files: both layouts, each pad length, black and white pixels
        queue_bitmap(OS2_HDR_SIZE, 1, 1, BPP_24, 0, 1, -1, FILL_BLACK);
        queue_bitmap(OS2_HDR_SIZE, 3, 2, BPP_24, 0, 1, -1, FILL_WHITE);
        queue_bitmap(WIN_HDR_LEN, 2, 2, BPP_24, 0, 1, -1, FILL_MIXED);
        queue_bitmap(WIN_HDR_LEN, 3, 2, BPP_32, 0, 1, -1, FILL_BLACK);
        queue_bitmap(V4_HDR_LEN, 4, 1, BPP_24, 0, 1, -1, FILL_WHITE);
        // trailing bytes are ignored
        repeat (5) queue_byte(8'($urandom), 1'b0);
        // unsupported formats, format error winning over size error
        queue_bitmap(OS2_HDR_SIZE, 2, 2, BPP_32, 0, 0, -1, FILL_MIXED);
        queue_bitmap(WIN_HDR_LEN, 2, 2, 16'd16, 0, 0, -1, FILL_MIXED);
        queue_bitmap(WIN_HDR_LEN, 2, 2, BPP_24, 32'd1, 0, -1, FILL_MIXED);
        queue_bitmap(WIN_HDR_LEN, 0, 2, 16'd8, 0, 0, -1, FILL_MIXED);
        // sizes out of range, negative width included
        queue_bitmap(WIN_HDR_LEN, 0, 2, BPP_24, 0, 0, -1, FILL_MIXED);
        queue_bitmap(WIN_HDR_LEN, 2, 0, BPP_32, 0, 0, -1, FILL_MIXED);
        queue_bitmap(WIN_HDR_LEN, DIM_LIMIT + 1, 1, BPP_24, 0, 0, -1, FILL_MIXED);
        queue_bitmap(WIN_HDR_LEN, 32'hFFFF_FFFF, 1, BPP_24, 0, 0, -1, FILL_MIXED);
        queue_bitmap(OS2_HDR_SIZE, 1, 32'h0000_FFFF, BPP_24, 0, 0, -1, FILL_MIXED);
        // restart within the header and within the pixel data
        queue_bitmap(WIN_HDR_LEN, 3, 3, BPP_24, 0, 1, 10, FILL_MIXED);
        queue_bitmap(WIN_HDR_LEN, 3, 3, BPP_24, 0, 1, 59, FILL_MIXED);
        queue_bitmap(OS2_HDR_SIZE, 2, 1, BPP_24, 0, 1, -1, FILL_MIXED);
        // largest width and largest height are accepted; first few pixels only
        queue_bitmap(WIN_HDR_LEN, DIM_LIMIT, 1, BPP_24, 0, 1, 66, FILL_MIXED);
        queue_bitmap(WIN_HDR_LEN, 1, DIM_LIMIT, BPP_32, 0, 1, 70, FILL_MIXED);
        settle_all();

        // random files
        mid_pause = 1'b0;
        mark      = queued_bytes;
        while (queued_bytes - mark < RANDOM_BYTES) begin
            if (!mid_pause && queued_bytes - mark >= RANDOM_BYTES / 2) begin
                mid_pause = 1'b1;
                settle_all();
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                // noise, now and then with a start flag
                repeat ($urandom_range(1, 6))
                    queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end else if (pick < 4) begin
                // header only, with random sizes, formats and compression, often broken
                os2  = ($urandom_range(0, 2) == 0);
                case ($urandom_range(0, 4))
                    0:       bpp = BPP_24;
                    1:       bpp = BPP_32;
                    2:       bpp = 16'd16;
                    3:       bpp = 16'd8;
                    default: bpp = 16'($urandom);
                endcase
                comp = ($urandom_range(0, 2) == 0) ? $urandom : 32'd0;
                queue_bitmap(os2 ? OS2_HDR_SIZE : WIN_HDR_LEN, odd_dimension(),
                             odd_dimension(), bpp, comp, 0, -1, FILL_MIXED);
                repeat ($urandom_range(0, 3)) queue_byte(8'($urandom), 1'b0);
            end else begin
                // well-formed file, sometimes cut short or followed by junk
                os2 = ($urandom_range(0, 3) == 0);
                bpp = (os2 || $urandom_range(0, 1) == 0) ? BPP_24 : BPP_32;
                queue_bitmap(os2 ? OS2_HDR_SIZE :
                             (($urandom_range(0, 3) == 0) ? $urandom : WIN_HDR_LEN),
                             ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20) :
                                                           $urandom_range(1, 6),
                             $urandom_range(1, 3), bpp, 0, 1,
                             ($urandom_range(0, 7) == 0) ? $urandom_range(2, 80) : -1,
                             FILL_MIXED);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 5)) queue_byte(8'($urandom), 1'b0);
            end
        end
        settle_all();
        repeat (20) @(negedge i_clk);

        if (bad_count == 0 && pixel_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
